FILE: sv/obl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, request codes and control struct for the byte log ring.
package obl_pkg;

  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned FILL_W   = IDX_W + 1;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned BYTE_W   = 8;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              byte_valid;
    logic [FILL_W-1:0] fill;
    logic              wrapped;
  } ctrl_t;

endpackage

FILE: sv/overwriting_byte_log_ring.sv
`timescale 1ns / 1ps
// Overwriting byte log ring: top level with store, control and result stages.
// An accepted beat reaches its result beat through the store read and then the result register.
// Throughput: one beat per cycle unless stalled; the registered store read sets pipeline depth.
// Reset: write index and wrapped mark clear at once; stored bytes stay undefined until written.
// in_stall_o rises only while both stages hold results and out_stall_i is high.
module overwriting_byte_log_ring (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [obl_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        line_end_i,
  input  logic [obl_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [obl_pkg::BYTE_W-1:0]  read_byte_o,
  output logic                        byte_valid_o,
  output logic [obl_pkg::FILL_W-1:0]  fill_count_o,
  output logic                        has_wrapped_o
);
  import obl_pkg::*;

  ctrl_t             ctrl;
  logic              accept;
  logic              s1_adv;
  logic [BYTE_W-1:0] rd_data;

  logic              s1_valid_q;
  logic              s1_bvalid_q;
  logic [FILL_W-1:0] s1_fill_q;
  logic              s1_wrap_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_bvalid_q;
  logic [FILL_W-1:0] out_fill_q;
  logic              out_wrap_q;
  logic              unused_line_end;

  assign unused_line_end = line_end_i;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  obl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .position_i  (position_i),
    .ctrl_o      (ctrl)
  );

  obl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl.wr_en),
    .wr_addr_i (ctrl.wr_addr),
    .wr_data_i (ctrl.wr_data),
    .rd_en_i   (ctrl.rd_en),
    .rd_addr_i (ctrl.rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bvalid_q <= ctrl.byte_valid;
      s1_fill_q   <= ctrl.fill;
      s1_wrap_q   <= ctrl.wrapped;
    end
    if (s1_adv) begin
      out_byte_q   <= s1_bvalid_q ? rd_data : '0;
      out_bvalid_q <= s1_bvalid_q;
      out_fill_q   <= s1_fill_q;
      out_wrap_q   <= s1_wrap_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_byte_o   = out_byte_q;
  assign byte_valid_o  = out_bvalid_q;
  assign fill_count_o  = out_fill_q;
  assign has_wrapped_o = out_wrap_q;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled without a held result");

  a_wrap_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_wrapped_o) |-> (fill_count_o == FILL_W'(CAPACITY)))
    else $error("wrapped result without full fill count");

  a_unwrap_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_wrapped_o) |-> (fill_count_o < FILL_W'(CAPACITY)))
    else $error("fill count at capacity without wrap");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (read_byte_o == '0))
    else $error("invalid result carries a nonzero byte");
`endif

endmodule

FILE: sv/obl_ram.sv
`timescale 1ns / 1ps
// Single write, single registered read byte store.
module obl_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/obl_ctrl.sv
`timescale 1ns / 1ps
// Write index, wrapped mark and per-beat address and status decode.
module obl_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [1:0]                  req_type_i,
  input  logic [obl_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [obl_pkg::POS_W-1:0]   position_i,
  output obl_pkg::ctrl_t              ctrl_o
);
  import obl_pkg::*;

  logic [IDX_W-1:0]  widx_q, widx_d;
  logic              wrap_q, wrap_d;
  logic [IDX_W-1:0]  widx_inc;
  logic [FILL_W-1:0] fill_cur;
  logic              in_range;
  req_e              req;

  assign req      = req_e'(req_type_i);
  assign widx_inc = widx_q + IDX_W'(1);
  assign fill_cur = wrap_q ? FILL_W'(CAPACITY) : {1'b0, widx_q};
  assign in_range = FILL_W'(position_i) < fill_cur;

  always_comb begin
    widx_d         = widx_q;
    wrap_d         = wrap_q;
    ctrl_o.wr_en   = 1'b0;
    ctrl_o.rd_en   = 1'b0;
    ctrl_o.byte_valid = 1'b0;
    ctrl_o.wr_addr = widx_q;
    ctrl_o.wr_data = data_byte_i;
    ctrl_o.rd_addr = wrap_q ? (widx_q + IDX_W'(position_i)) : IDX_W'(position_i);
    case (req)
      REQ_APPEND: begin
        ctrl_o.wr_en = accept_i;
        widx_d       = widx_inc;
        if (widx_inc == '0) begin
          wrap_d = 1'b1;
        end
      end
      REQ_READ: begin
        ctrl_o.rd_en      = accept_i && in_range;
        ctrl_o.byte_valid = in_range;
      end
      REQ_CLEAR: begin
        widx_d = '0;
        wrap_d = 1'b0;
      end
      default: begin
      end
    endcase
    ctrl_o.fill    = wrap_d ? FILL_W'(CAPACITY) : {1'b0, widx_d};
    ctrl_o.wrapped = wrap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      wrap_q <= 1'b0;
    end else if (accept_i) begin
      widx_q <= widx_d;
      wrap_q <= wrap_d;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the byte log ring: directed table, then random append/read/clear/no-op traffic.
module testbench;
  import obl_pkg::*;

  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned N_DIR       = 22;
  localparam int unsigned N_MIXED     = 450;
  localparam int unsigned N_WRAPPED   = 450;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_byte;
    logic              hit;
    logic [FILL_W-1:0] fill;
    logic              wrapped;
  } ring_reply_t;

  typedef struct packed {
    req_e              req;
    logic [BYTE_W-1:0] data;
    logic              le;
    logic [POS_W-1:0]  pos;
    logic              typed;
    ring_reply_t       reply;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [1:0]          req_type_i  = '0;
  logic [BYTE_W-1:0]   data_byte_i = '0;
  logic                line_end_i  = 1'b0;
  logic [POS_W-1:0]    position_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [BYTE_W-1:0]   read_byte_o;
  logic                byte_valid_o;
  logic [FILL_W-1:0]   fill_count_o;
  logic                has_wrapped_o;

  logic [BYTE_W-1:0]   log_mem [CAPACITY];
  logic [IDX_W-1:0]    wr_idx    = '0;
  logic                ring_full = 1'b0;
  ring_reply_t         ring_reply_q [$];
  dir_row_t            dir_tab [N_DIR];

  bit                  steady_in = 1'b0;
  int unsigned         n_cycles  = 0;
  int unsigned         n_err     = 0;
  int unsigned         n_append, n_read_hit, n_read_miss, n_clear, n_nop, n_wraps;

  overwriting_byte_log_ring i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .data_byte_i   (data_byte_i),
    .line_end_i    (line_end_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_byte_o   (read_byte_o),
    .byte_valid_o  (byte_valid_o),
    .fill_count_o  (fill_count_o),
    .has_wrapped_o (has_wrapped_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic logic [FILL_W-1:0] held_bytes();
    return ring_full ? FILL_W'(CAPACITY) : FILL_W'(wr_idx);
  endfunction

  function automatic ring_reply_t ring_reply_for(req_e req, logic [BYTE_W-1:0] data,
                                                 logic [POS_W-1:0] pos);
    ring_reply_t      r;
    logic [IDX_W-1:0] addr;
    r = '0;
    case (req)
      REQ_APPEND: begin
        log_mem[wr_idx] = data;
        wr_idx = wr_idx + 1'b1;
        if (wr_idx == '0) ring_full = 1'b1;
      end
      REQ_READ: begin
        if (FILL_W'(pos) < held_bytes()) begin
          addr      = ring_full ? IDX_W'(wr_idx + pos) : IDX_W'(pos);
          r.rd_byte = log_mem[addr];
          r.hit     = 1'b1;
        end
      end
      REQ_CLEAR: begin
        wr_idx    = '0;
        ring_full = 1'b0;
      end
      default: ;
    endcase
    r.fill    = held_bytes();
    r.wrapped = ring_full;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 39) == 0) steady_in = !steady_in;
    if (steady_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int                r;
    logic [FILL_W-1:0] f;
    f = held_bytes();
    r = $urandom_range(0, 99);
    if (r < 60 && f != 0) return POS_W'($urandom_range(0, f - 1));
    if (r < 70) return POS_W'(f);
    if (r < 78 && f != 0) return POS_W'(f - 1);
    if (r < 84) return '1;
    if (r < 88) return '0;
    return POS_W'($urandom);
  endfunction

  task automatic send_beat(req_e req, logic [BYTE_W-1:0] data, logic le, logic [POS_W-1:0] pos,
                           logic typed, ring_reply_t typed_reply);
    int          gap;
    bit          was_full;
    ring_reply_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= data;
    line_end_i  <= le;
    position_i  <= pos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    was_full = ring_full;
    r = ring_reply_for(req, data, pos);
    ring_reply_q.push_back(typed ? typed_reply : r);
    case (req)
      REQ_APPEND: n_append++;
      REQ_READ:   if (r.hit) n_read_hit++; else n_read_miss++;
      REQ_CLEAR:  n_clear++;
      default:    n_nop++;
    endcase
    if (!was_full && ring_full) n_wraps++;
  endtask

  task automatic random_beat(int w_app, int w_rd, int w_clr);
    int   r;
    req_e req;
    r = $urandom_range(0, 99);
    if (r < w_app) req = REQ_APPEND;
    else if (r < w_app + w_rd) req = REQ_READ;
    else if (r < w_app + w_rd + w_clr) req = REQ_CLEAR;
    else req = REQ_NOP;
    send_beat(req, BYTE_W'($urandom), 1'($urandom), pick_position(), 1'b0, '0);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ring_reply_q.size() != 0);
  endtask

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      n_err++;
    end
  endfunction

  // hold the receiver off in random stretches
  initial begin : out_stall_gen
    forever begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clk_i);
      else repeat ($urandom_range(1, 8)) @(posedge clk_i);
      out_stall_i <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 40)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : reply_check
    ring_reply_t exp_r;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (ring_reply_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual byte %0h valid %0b fill %0d",
                 $time, read_byte_o, byte_valid_o, fill_count_o);
        n_err++;
      end else begin
        exp_r = ring_reply_q.pop_front();
        check_field("read_byte",   exp_r.rd_byte, read_byte_o);
        check_field("byte_valid",  exp_r.hit,     byte_valid_o);
        check_field("fill_count",  exp_r.fill,    fill_count_o);
        check_field("has_wrapped", exp_r.wrapped, has_wrapped_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int extra;
    dir_tab = '{
      '{REQ_READ,   8'h00, 1'b0, 12'd0,    1'b1, '{8'h00, 1'b0, 13'd0, 1'b0}},
      '{REQ_READ,   8'h00, 1'b0, 12'hfff,  1'b1, '{8'h00, 1'b0, 13'd0, 1'b0}},
      '{REQ_NOP,    8'hff, 1'b1, 12'hfff,  1'b1, '{8'h00, 1'b0, 13'd0, 1'b0}},
      '{REQ_CLEAR,  8'h00, 1'b0, 12'd0,    1'b1, '{8'h00, 1'b0, 13'd0, 1'b0}},
      '{REQ_APPEND, 8'h00, 1'b0, 12'd0,    1'b1, '{8'h00, 1'b0, 13'd1, 1'b0}},
      '{REQ_APPEND, 8'hff, 1'b1, 12'hfff,  1'b1, '{8'h00, 1'b0, 13'd2, 1'b0}},
      '{REQ_READ,   8'h00, 1'b0, 12'd0,    1'b1, '{8'h00, 1'b1, 13'd2, 1'b0}},
      '{REQ_READ,   8'h00, 1'b0, 12'd1,    1'b1, '{8'hff, 1'b1, 13'd2, 1'b0}},
      '{REQ_READ,   8'h00, 1'b0, 12'd2,    1'b1, '{8'h00, 1'b0, 13'd2, 1'b0}},
      '{REQ_READ,   8'hff, 1'b1, 12'hfff,  1'b1, '{8'h00, 1'b0, 13'd2, 1'b0}},
      '{REQ_APPEND, 8'h80, 1'b0, 12'h800,  1'b0, '0},
      '{REQ_APPEND, 8'h01, 1'b1, 12'd0,    1'b0, '0},
      '{REQ_READ,   8'h00, 1'b0, 12'd2,    1'b0, '0},
      '{REQ_READ,   8'h00, 1'b0, 12'd3,    1'b0, '0},
      '{REQ_NOP,    8'hff, 1'b1, 12'hfff,  1'b0, '0},
      '{REQ_APPEND, 8'h7f, 1'b0, 12'd0,    1'b0, '0},
      '{REQ_CLEAR,  8'hff, 1'b1, 12'hfff,  1'b1, '{8'h00, 1'b0, 13'd0, 1'b0}},
      '{REQ_READ,   8'h00, 1'b0, 12'd0,    1'b1, '{8'h00, 1'b0, 13'd0, 1'b0}},
      '{REQ_APPEND, 8'h5a, 1'b1, 12'd0,    1'b1, '{8'h00, 1'b0, 13'd1, 1'b0}},
      '{REQ_READ,   8'h00, 1'b0, 12'd0,    1'b1, '{8'h5a, 1'b1, 13'd1, 1'b0}},
      '{REQ_READ,   8'h00, 1'b0, 12'd1,    1'b0, '0},
      '{REQ_NOP,    8'h00, 1'b0, 12'd0,    1'b0, '0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      send_beat(dir_tab[i].req, dir_tab[i].data, dir_tab[i].le, dir_tab[i].pos,
                dir_tab[i].typed, dir_tab[i].reply);
    drain_replies();

    repeat (N_MIXED) random_beat(60, 30, 3);
    drain_replies();

    // fill past the wrap point, then keep the ring full for a while
    extra = $urandom_range(50, 400);
    while (!ring_full || extra > 0) begin
      if (ring_full) extra--;
      random_beat(95, 5, 0);
    end
    repeat (N_WRAPPED) random_beat(40, 55, 0);
    drain_replies();

    repeat (N_MIXED) random_beat(55, 30, 8);
    drain_replies();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d appends, %0d reads in range, %0d reads out of range,",
             n_append, n_read_hit, n_read_miss);
    $display("%0d clears, %0d no-op beats and %0d wraps of the ring.", n_clear, n_nop, n_wraps);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/obl_pkg.sv
sv/obl_ram.sv
sv/obl_ctrl.sv
sv/overwriting_byte_log_ring.sv
tb/testbench.sv
